@@ hdl/spos_pkg.sv @@
// Shared types, constants and codes for the slot pool with oldest-slot steal.
package spos_pkg;

    localparam int POOL_SLOTS_DEF = 16;
    localparam int SLOT_W         = 4;
    localparam int STATUS_W       = 3;
    localparam int LIMIT_W        = 5;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 5;

    localparam logic [LIMIT_W-1:0] SLOTS_IN_USE_RST = 5'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOTS_IN_USE = 1'b0,
        CFG_STEAL        = 1'b1
    } t_cfg_reg;

    typedef enum logic [0:0] {
        ACT_ACQUIRE = 1'b0,
        ACT_RELEASE = 1'b1
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED  = 3'd0,
        ST_STOLEN   = 3'd1,
        ST_NONE     = 3'd2,
        ST_RELEASED = 3'd3,
        ST_IGNORED  = 3'd4
    } t_status;

    typedef struct packed {
        logic              action;
        logic [SLOT_W-1:0] slot_number;
    } t_item;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] granted_slot;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_WALK,
        S_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clr_flag;
        logic scan_adv;
        logic grant;
        logic walk;
        logic finish;
        logic resp_ignored;
        logic resp_none;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_release;
        logic rel_ok;
        logic scan_hit;
        logic scan_end;
        logic can_steal;
        logic walk_done;
    } t_stat;

endpackage

@@ hdl/spos_ctrl.sv @@
// Sequencer for acquire, steal and release beats of the slot pool.
module spos_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  spos_pkg::t_stat i_stat,
    output spos_pkg::t_cmd  o_cmd,
    output logic           busy
);
    import spos_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.is_release) begin
                    n_state = i_stat.rel_ok ? S_WALK : S_IDLE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_hit) begin
                    n_state = S_IDLE;
                end else if (i_stat.scan_end) begin
                    n_state = i_stat.can_steal ? S_WALK : S_IDLE;
                end
            end
            S_WALK: begin
                if (i_stat.walk_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            S_CHECK: begin
                if (i_stat.is_release) begin
                    o_cmd.clr_flag     = i_stat.rel_ok;
                    o_cmd.resp_ignored = !i_stat.rel_ok;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_hit) begin
                    o_cmd.grant = 1'b1;
                end else if (i_stat.scan_end) begin
                    o_cmd.resp_none = !i_stat.can_steal;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

@@ hdl/spos_datapath.sv @@
// Slot flags, age list memory, counters and result register of the slot pool.
module spos_datapath #(
    parameter int POOL_SLOTS = spos_pkg::POOL_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [spos_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [spos_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  spos_pkg::t_item                   i_item,
    input  spos_pkg::t_cmd                    i_cmd,
    output spos_pkg::t_stat                   o_stat,
    output spos_pkg::t_result                 o_result,
    output logic                              o_done
);
    import spos_pkg::*;

    localparam int SW   = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int CW   = $clog2(POOL_SLOTS + 1);
    localparam int CMPW = (CW > SLOT_W) ? CW : SLOT_W;
    localparam int LW   = (CW > LIMIT_W) ? CW : LIMIT_W;

    // configuration
    logic [LIMIT_W-1:0]    r_slots_in_use;
    logic                  r_steal;

    // pool state
    logic [POOL_SLOTS-1:0] r_flags;
    logic [CW-1:0]         r_count;
    logic [SW-1:0]         r_mem [POOL_SLOTS];
    logic [SW-1:0]         r_rdata;

    // current beat
    logic                  r_action;
    logic [SLOT_W-1:0]     r_slot;
    logic [CW-1:0]         r_scan;
    logic [CW-1:0]         r_walk;
    logic                  r_rd_vld;
    logic [SW-1:0]         r_rd_pos;
    logic                  r_found;
    logic [SW-1:0]         r_victim;

    t_result               r_result;
    logic                  r_done;

    logic [LW-1:0]         sl_ext;
    logic [CW-1:0]         limit;
    logic [SW-1:0]         slot_idx;
    logic                  rel_ok;
    logic                  scan_end;
    logic                  scan_hit;
    logic                  issue;
    logic                  proc;
    logic                  match;
    logic [SW-1:0]         rd_addr;
    logic                  w_we;
    logic [SW-1:0]         w_addr;
    logic [SW-1:0]         w_data;

    assign sl_ext   = LW'(r_slots_in_use);
    assign limit    = (sl_ext > LW'(POOL_SLOTS)) ? CW'(POOL_SLOTS) : CW'(sl_ext);
    assign slot_idx = SW'(r_slot);
    assign rel_ok   = (CMPW'(r_slot) < CMPW'(POOL_SLOTS)) && r_flags[slot_idx];
    assign scan_end = (r_scan >= limit);
    assign scan_hit = !scan_end && !r_flags[r_scan[SW-1:0]];

    // walk the list one entry a cycle; once the target is found, move each later
    // entry up by one place as its read data comes back
    assign issue   = i_cmd.walk && (r_walk < r_count);
    assign proc    = i_cmd.walk && r_rd_vld;
    assign rd_addr = r_walk[SW-1:0];
    assign match   = (r_action == ACT_RELEASE) ? (CMPW'(r_rdata) == CMPW'(r_slot))
                                               : (r_rd_pos == '0);

    always_comb begin
        w_we   = 1'b0;
        w_addr = '0;
        w_data = '0;
        if (proc && r_found) begin
            w_we   = 1'b1;
            w_addr = r_rd_pos - SW'(1);
            w_data = r_rdata;
        end else if (i_cmd.grant) begin
            w_we   = 1'b1;
            w_addr = r_count[SW-1:0];
            w_data = r_scan[SW-1:0];
        end else if (i_cmd.finish && (r_action == ACT_ACQUIRE)) begin
            // steal: the oldest slot goes to the tail
            w_we   = 1'b1;
            w_addr = SW'(r_count - CW'(1));
            w_data = r_victim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_in_use <= SLOTS_IN_USE_RST;
            r_steal        <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_SLOTS_IN_USE: r_slots_in_use <= i_cfg_data[LIMIT_W-1:0];
                CFG_STEAL:        r_steal        <= i_cfg_data[0];
                default:          r_steal        <= r_steal;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_item.action;
            r_slot   <= i_item.slot_number;
        end
        if (proc && !r_found && match) begin
            r_victim <= r_rdata;
        end
        if (issue) begin
            r_rd_pos <= r_walk[SW-1:0];
        end
        if (i_cmd.grant) begin
            r_result.status       <= ST_GRANTED;
            r_result.granted_slot <= SLOT_W'(r_scan);
        end else if (i_cmd.finish) begin
            if (r_action == ACT_RELEASE) begin
                r_result.status       <= ST_RELEASED;
                r_result.granted_slot <= r_slot;
            end else begin
                r_result.status       <= ST_STOLEN;
                r_result.granted_slot <= SLOT_W'(r_victim);
            end
        end else if (i_cmd.resp_ignored) begin
            r_result.status       <= ST_IGNORED;
            r_result.granted_slot <= '0;
        end else if (i_cmd.resp_none) begin
            r_result.status       <= ST_NONE;
            r_result.granted_slot <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags  <= '0;
            r_count  <= '0;
            r_scan   <= '0;
            r_walk   <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done   <= i_cmd.grant || i_cmd.finish || i_cmd.resp_ignored
                        || i_cmd.resp_none;
            r_rd_vld <= issue;
            if (i_cmd.load) begin
                r_scan  <= '0;
                r_walk  <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.scan_adv) begin
                r_scan <= r_scan + CW'(1);
            end
            if (issue) begin
                r_walk <= r_walk + CW'(1);
            end
            if (proc && !r_found && match) begin
                r_found <= 1'b1;
            end
            if (i_cmd.clr_flag) begin
                r_flags[slot_idx] <= 1'b0;
            end
            if (i_cmd.grant) begin
                r_flags[r_scan[SW-1:0]] <= 1'b1;
                r_count                 <= r_count + CW'(1);
            end
            if (i_cmd.finish && (r_action == ACT_RELEASE)) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    assign o_stat.is_release = (r_action == ACT_RELEASE);
    assign o_stat.rel_ok     = rel_ok;
    assign o_stat.scan_hit   = scan_hit;
    assign o_stat.scan_end   = scan_end;
    assign o_stat.can_steal  = r_steal && (r_count != '0);
    assign o_stat.walk_done  = (r_walk == r_count) && !r_rd_vld;

    assign o_result = r_result;
    assign o_done   = r_done;

endmodule

@@ hdl/slot_pool_oldest_steal_unit.sv @@
// An acquire scans the slots from slot 0 up to the limit; a release walks the age list, and a steal
// scans to the limit and then walks the list. One beat at a time: the list walk through the single
// read port of the age list memory sets the rate, busy stays high until the result strobe.
// The result is on o_result for one cycle with o_done; the receiver cannot stall it.
// Synchronous reset clears all slot flags, the active count and the configuration registers to defaults.
module slot_pool_oldest_steal_unit #(
    parameter int POOL_SLOTS = spos_pkg::POOL_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [spos_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [spos_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            start,
    input  spos_pkg::t_item                 i_item,
    output logic                            busy,
    output spos_pkg::t_result               o_result,
    output logic                            o_done
);
    import spos_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    spos_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    spos_datapath #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_result   (o_result),
        .o_done     (o_done)
    );

endmodule

@@ tb/tb_slot_pool_oldest_steal_unit.sv @@
// Self-checking testbench for the slot pool with oldest-slot steal.
`timescale 1ns / 100ps

module tb_slot_pool_oldest_steal_unit;
    import spos_pkg::*;

    localparam int POOL           = POOL_SLOTS_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RAND_PHASES    = 8;
    localparam int PHASE_BEATS    = 100;
    localparam int DRAIN_CYCLES   = 60;

    typedef enum logic {
        ROW_BEAT,
        ROW_WRITE
    } t_row_kind;

    typedef struct {
        t_row_kind         kind;
        t_cfg_reg          reg_idx;
        logic [CFG_DATA_W-1:0] wdata;
        t_item             item;
        bit                typed;
        t_result           want;
    } t_dir_row;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  start      = 1'b0;
    t_item                 i_item     = '0;
    logic                  busy;
    t_result               o_result;
    logic                  o_done;

    // predictor state and register copies
    logic [LIMIT_W-1:0] lim_reg;
    bit                 steal_reg;
    bit                 slot_live [POOL];
    logic [SLOT_W-1:0]  age_list [POOL];
    int                 live_count;

    t_result  pending_grants [$];
    t_dir_row directed_rows [$];
    int       fail_count    = 0;
    int       beats_in      = 0;
    int       results_seen  = 0;
    int       settings_used = 0;
    int       status_tally [5];
    int       quiet_cycles  = 0;

    slot_pool_oldest_steal_unit #(
        .POOL_SLOTS(POOL)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .start     (start),
        .i_item    (i_item),
        .busy      (busy),
        .o_result  (o_result),
        .o_done    (o_done)
    );

    always #5 i_clk = ~i_clk;

    // Grant, steal or release in the pool copy and return the outcome of the beat.
    function automatic t_result pool_outcome(t_item it);
        t_result           r;
        int                lim;
        int                pick;
        int                pos;
        logic [SLOT_W-1:0] oldest;
        r.status       = ST_NONE;
        r.granted_slot = '0;
        pick           = -1;
        pos            = -1;
        if (it.action == ACT_ACQUIRE) begin
            lim = (int'(lim_reg) > POOL) ? POOL : int'(lim_reg);
            for (int k = lim - 1; k >= 0; k--)
                if (!slot_live[k]) pick = k;
            if (pick >= 0) begin
                slot_live[pick]      = 1'b1;
                age_list[live_count] = SLOT_W'(pick);
                live_count++;
                r.status       = ST_GRANTED;
                r.granted_slot = SLOT_W'(pick);
            end else if (steal_reg && live_count > 0) begin
                // rotate the oldest entry to the tail
                oldest = age_list[0];
                for (int k = 0; k < live_count - 1; k++)
                    age_list[k] = age_list[k + 1];
                age_list[live_count - 1] = oldest;
                r.status       = ST_STOLEN;
                r.granted_slot = oldest;
            end
        end else if (slot_live[it.slot_number]) begin
            slot_live[it.slot_number] = 1'b0;
            for (int k = 0; k < live_count; k++)
                if (pos < 0 && age_list[k] == it.slot_number) pos = k;
            for (int k = pos; k < live_count - 1; k++)
                age_list[k] = age_list[k + 1];
            live_count--;
            r.status       = ST_RELEASED;
            r.granted_slot = it.slot_number;
        end else begin
            r.status = ST_IGNORED;
        end
        return r;
    endfunction

    function automatic t_dir_row beat_row(t_action act, logic [SLOT_W-1:0] slot, bit typed,
                                          t_status st, logic [SLOT_W-1:0] gs);
        t_dir_row row;
        row.kind               = ROW_BEAT;
        row.reg_idx            = CFG_SLOTS_IN_USE;
        row.wdata              = '0;
        row.item.action        = act;
        row.item.slot_number   = slot;
        row.typed              = typed;
        row.want.status        = st;
        row.want.granted_slot  = gs;
        return row;
    endfunction

    function automatic t_dir_row write_row(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        t_dir_row row;
        row       = beat_row(ACT_ACQUIRE, '0, 1'b0, ST_GRANTED, '0);
        row.kind  = ROW_WRITE;
        row.reg_idx = idx;
        row.wdata = data;
        return row;
    endfunction

    task automatic pause_sender(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic offer_beat(input t_item it, input bit typed, input t_result want);
        t_result got;
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        got = pool_outcome(it);
        status_tally[got.status]++;
        pending_grants.push_back(typed ? want : got);
        beats_in++;
    endtask

    // Drain the block, then write one register.
    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        start <= 1'b0;
        do @(posedge i_clk); while (pending_grants.size() != 0 || busy);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_SLOTS_IN_USE)
            lim_reg = data[LIMIT_W-1:0];
        else
            steal_reg = data[0];
        settings_used++;
    endtask

    initial begin
        t_item   it;
        t_result none_due;
        int      bias;
        bit      steady;
        lim_reg    = SLOTS_IN_USE_RST;
        steal_reg  = 1'b0;
        live_count = 0;
        none_due   = '0;
        foreach (slot_live[k]) slot_live[k] = 1'b0;
        foreach (age_list[k]) age_list[k] = '0;
        foreach (status_tally[k]) status_tally[k] = 0;

        directed_rows = '{
            beat_row(ACT_RELEASE, 4'd5,  1'b1, ST_IGNORED,  4'd0),
            beat_row(ACT_ACQUIRE, 4'd0,  1'b1, ST_GRANTED,  4'd0),
            beat_row(ACT_ACQUIRE, 4'd15, 1'b1, ST_GRANTED,  4'd1),
            beat_row(ACT_RELEASE, 4'd15, 1'b1, ST_IGNORED,  4'd0),
            beat_row(ACT_RELEASE, 4'd0,  1'b1, ST_RELEASED, 4'd0),
            beat_row(ACT_ACQUIRE, 4'd3,  1'b0, ST_GRANTED,  4'd0),
            write_row(CFG_SLOTS_IN_USE, 5'd2),
            beat_row(ACT_ACQUIRE, 4'd0,  1'b1, ST_NONE,     4'd0),
            write_row(CFG_STEAL, 5'd1),
            beat_row(ACT_ACQUIRE, 4'd0,  1'b0, ST_GRANTED,  4'd0),
            beat_row(ACT_ACQUIRE, 4'd9,  1'b0, ST_GRANTED,  4'd0),
            write_row(CFG_SLOTS_IN_USE, 5'd0),
            beat_row(ACT_RELEASE, 4'd1,  1'b0, ST_GRANTED,  4'd0),
            beat_row(ACT_ACQUIRE, 4'd0,  1'b0, ST_GRANTED,  4'd0),
            beat_row(ACT_RELEASE, 4'd0,  1'b0, ST_GRANTED,  4'd0),
            // steal allowed but nothing active
            beat_row(ACT_ACQUIRE, 4'd0,  1'b1, ST_NONE,     4'd0),
            write_row(CFG_SLOTS_IN_USE, 5'd31),
            write_row(CFG_STEAL, 5'b11110),
            beat_row(ACT_ACQUIRE, 4'd0,  1'b1, ST_GRANTED,  4'd0),
            beat_row(ACT_ACQUIRE, 4'd0,  1'b0, ST_GRANTED,  4'd0),
            beat_row(ACT_ACQUIRE, 4'd0,  1'b0, ST_GRANTED,  4'd0),
            // lower the limit below the active slots
            write_row(CFG_SLOTS_IN_USE, 5'd1),
            beat_row(ACT_ACQUIRE, 4'd0,  1'b1, ST_NONE,     4'd0),
            write_row(CFG_STEAL, 5'b00001),
            beat_row(ACT_ACQUIRE, 4'd0,  1'b0, ST_GRANTED,  4'd0),
            beat_row(ACT_ACQUIRE, 4'd0,  1'b0, ST_GRANTED,  4'd0),
            beat_row(ACT_RELEASE, 4'd2,  1'b0, ST_GRANTED,  4'd0),
            beat_row(ACT_RELEASE, 4'd15, 1'b1, ST_IGNORED,  4'd0),
            beat_row(ACT_ACQUIRE, 4'd15, 1'b0, ST_GRANTED,  4'd0)
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_WRITE)
                write_reg(directed_rows[r].reg_idx, directed_rows[r].wdata);
            else
                offer_beat(directed_rows[r].item, directed_rows[r].typed,
                           directed_rows[r].want);
        end

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_SLOTS_IN_USE, 5'd16);
                    write_reg(CFG_STEAL, {4'($urandom), 1'b1});
                end
                1: begin
                    write_reg(CFG_SLOTS_IN_USE, 5'd31);
                    write_reg(CFG_STEAL, {4'($urandom), 1'b0});
                end
                2: begin
                    write_reg(CFG_SLOTS_IN_USE, 5'd0);
                    write_reg(CFG_STEAL, {4'($urandom), 1'b1});
                end
                3: begin
                    write_reg(CFG_SLOTS_IN_USE, 5'd1);
                    write_reg(CFG_STEAL, {4'($urandom), 1'b1});
                end
                default: begin
                    write_reg(CFG_SLOTS_IN_USE, 5'($urandom_range(0, 31)));
                    write_reg(CFG_STEAL, 5'($urandom));
                end
            endcase
            bias   = (phase % 3 == 0) ? 80 : (phase % 3 == 1) ? 55 : 30;
            // hold start high back to back through these phases
            steady = (phase == 3 || phase == 4);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                it.slot_number = SLOT_W'($urandom);
                if ($urandom_range(0, 99) < bias) begin
                    it.action = ACT_ACQUIRE;
                end else begin
                    it.action = ACT_RELEASE;
                    if (live_count > 0 && $urandom_range(0, 3) != 0)
                        it.slot_number = age_list[$urandom_range(0, live_count - 1)];
                end
                offer_beat(it, 1'b0, none_due);
                if (!steady && $urandom_range(0, 99) < 20)
                    pause_sender($urandom_range(1, 5));
            end
        end

        start <= 1'b0;
        do @(posedge i_clk); while (pending_grants.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_grants.size() != 0) begin
            $error("%0d expected results never arrived", pending_grants.size());
            fail_count++;
        end

        $display("%0d beats offered, %0d results checked, %0d register writes",
                 beats_in, results_seen, settings_used);
        $display("outcomes: %0d idle grants, %0d steals, %0d none, %0d releases, %0d ignored",
                 status_tally[ST_GRANTED], status_tally[ST_STOLEN], status_tally[ST_NONE],
                 status_tally[ST_RELEASED], status_tally[ST_IGNORED]);
        if (fail_count == 0) begin
            $display("slot_pool_oldest_steal_unit verification clean");
        end else begin
            $display("slot_pool_oldest_steal_unit verification failed");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        t_result due;
        if (i_rst_n && o_done) begin
            if (pending_grants.size() == 0) begin
                $error("result beat with nothing pending: status %0d slot %0d",
                       o_result.status, o_result.granted_slot);
                fail_count++;
            end else begin
                due = pending_grants.pop_front();
                results_seen++;
                if (o_result.status !== due.status) begin
                    $error("status: expected %0d, got %0d", due.status, o_result.status);
                    fail_count++;
                end
                if (o_result.granted_slot !== due.granted_slot) begin
                    $error("granted_slot: expected %0d, got %0d",
                           due.granted_slot, o_result.granted_slot);
                    fail_count++;
                end
            end
        end
    end

    // Stop a hung run: count cycles with no beat taken in either direction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("slot_pool_oldest_steal_unit verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
